// File: src/lfucl_pkg.sv
// Shared constants and sequencer types for the LFU cache with LRU tie-break.
// No dependencies; imported by lfucl_apb, the top level and the testbench.
package lfucl_pkg;

    localparam int unsigned ENTRIES_DEF   = 16;
    localparam int unsigned FREQ_BITS_DEF = 16;
    localparam int unsigned CAP_W         = 5;
    localparam int unsigned KEY_W         = 32;
    localparam int unsigned VAL_W         = 32;
    localparam int unsigned CAP_RESET     = 16;

    // Request kinds
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // APB register word indexes
    localparam logic REG_CAPACITY = 1'b0;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SWEEP  = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    // What the current table sweep is for
    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_TOUCH  = 2'd1,
        MODE_EVICT  = 2'd2
    } mode_t;

endpackage

// File: src/lfucl_ram.sv
// Single-port-write, single-port-read entry store with registered read data.
// Depends on nothing beyond its parameters.
module lfucl_ram #(
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned ADDR_W = 4,
    parameter int unsigned DATA_W = 84
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// File: src/lfucl_apb.sv
// APB register file holding the capacity register.
// Depends on lfucl_pkg.
module lfucl_apb
    import lfucl_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [CAP_W-1:0] capacity
);

    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] cap_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == {REG_CAPACITY, 2'b00});

    always_comb begin
        cap_next = cap_reg;
        if (wr_en) begin
            cap_next = pwdata[CAP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_W'(CAP_RESET);
        end else begin
            cap_reg <= cap_next;
        end
    end

    // read back
    assign prdata   = (paddr == {REG_CAPACITY, 2'b00}) ? {{(32-CAP_W){1'b0}}, cap_reg} : 32'd0;
    assign capacity = cap_reg;

endmodule

// File: src/lfu_cache_with_lru_tiebreak_unit.sv
// LFU key-value cache with LRU tie-break: top level with the request sequencer.
// Depends on lfucl_pkg, lfucl_ram and lfucl_apb.
//
// Each request beat (get or put) gives exactly one result beat. Entries live in
// one synchronous RAM; the sequencer sweeps it one entry a cycle, and each sweep
// is followed by a decide state. A miss that evicts nothing takes one lookup sweep,
// a hit takes a lookup sweep plus a recency update sweep, and a put miss on a full
// table adds an eviction sweep per eviction (normally one). The next request is
// accepted in the idle state after its predecessor's result is registered. A new
// request is taken while the previous result still waits in the output register;
// a second finished result waits until that register drains.
// No clearing pass is needed after reset.
module lfu_cache_with_lru_tiebreak_unit
    import lfucl_pkg::*;
#(
    parameter int unsigned ENTRIES   = ENTRIES_DEF,
    parameter int unsigned FREQ_BITS = FREQ_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [31:0] key, [63:32] value
    input  logic        s_tuser,    // [0] op
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] read_value
    output logic        m_tuser,    // [0] hit
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW   = $clog2(ENTRIES + 1);
    localparam int unsigned FB   = FREQ_BITS;
    localparam int unsigned DW   = KEY_W + VAL_W + FB + AW;
    localparam int unsigned VOFS = KEY_W;
    localparam int unsigned FOFS = KEY_W + VAL_W;
    localparam int unsigned AOFS = KEY_W + VAL_W + FB;
    localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);
    localparam logic [FB-1:0] FREQ_MAX = {FB{1'b1}};

    logic [CAP_W-1:0] capacity;

    lfucl_apb u_apb (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    // entry store
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    lfucl_ram #(
        .DEPTH  (ENTRIES),
        .ADDR_W (AW),
        .DATA_W (DW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // control state
    state_t             state_reg, state_next;
    mode_t              mode_reg, mode_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW:0]        iss_reg, iss_next;
    logic               pvld_reg, pvld_next;
    logic [AW-1:0]      pidx_reg, pidx_next;
    logic               adj_reg, adj_next;
    logic               touch_reg, touch_next;
    logic [AW-1:0]      skip_reg, skip_next;
    logic [AW-1:0]      thr_reg, thr_next;
    logic               found_reg, found_next;
    logic               vic_reg, vic_next;
    logic               free_reg, free_next;
    logic               m_valid_reg, m_valid_next;

    // payload
    logic               op_reg, op_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [VAL_W-1:0]   val_reg, val_next;
    logic [AW-1:0]      fidx_reg, fidx_next;
    logic [AW-1:0]      fage_reg, fage_next;
    logic [VAL_W-1:0]   fval_reg, fval_next;
    logic [AW-1:0]      vidx_reg, vidx_next;
    logic [FB-1:0]      vfreq_reg, vfreq_next;
    logic [AW-1:0]      vage_reg, vage_next;
    logic [AW-1:0]      frx_reg, frx_next;
    logic               rhit_reg, rhit_next;
    logic [VAL_W-1:0]   rval_reg, rval_next;
    logic               m_hit_reg, m_hit_next;
    logic [VAL_W-1:0]   m_data_reg, m_data_next;

    // fields of the entry coming back from the RAM
    logic [KEY_W-1:0] e_key;
    logic [VAL_W-1:0] e_val;
    logic [FB-1:0]    e_freq;
    logic [AW-1:0]    e_age;
    logic [AW-1:0]    adj_age;
    logic             cur_v;
    logic             do_adj;
    logic             is_touch;
    logic [31:0]      eff_cap;
    logic             need_evict;

    assign e_key  = ram_rdata[KEY_W-1:0];
    assign e_val  = ram_rdata[VOFS +: VAL_W];
    assign e_freq = ram_rdata[FOFS +: FB];
    assign e_age  = ram_rdata[AOFS +: AW];
    assign cur_v  = valid_reg[pidx_reg];

    // close the recency gap left by the skipped entry
    assign do_adj   = adj_reg && cur_v && (pidx_reg != skip_reg) && (e_age > thr_reg);
    assign adj_age  = do_adj ? (e_age - AW'(1)) : e_age;
    assign is_touch = touch_reg && (pidx_reg == skip_reg);

    // effective capacity, clipped to the table depth
    assign eff_cap    = ({{(32-CAP_W){1'b0}}, capacity} > 32'(ENTRIES)) ?
                        32'(ENTRIES) : {{(32-CAP_W){1'b0}}, capacity};
    assign need_evict = (32'(count_reg) >= eff_cap) && (count_reg != '0);

    assign ram_raddr = iss_reg[AW-1:0];

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        valid_next   = valid_reg;
        count_next   = count_reg;
        iss_next     = iss_reg;
        pvld_next    = 1'b0;
        pidx_next    = pidx_reg;
        adj_next     = adj_reg;
        touch_next   = touch_reg;
        skip_next    = skip_reg;
        thr_next     = thr_reg;
        found_next   = found_reg;
        vic_next     = vic_reg;
        free_next    = free_reg;
        m_valid_next = m_valid_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        val_next     = val_reg;
        fidx_next    = fidx_reg;
        fage_next    = fage_reg;
        fval_next    = fval_reg;
        vidx_next    = vidx_reg;
        vfreq_next   = vfreq_reg;
        vage_next    = vage_reg;
        frx_next     = frx_reg;
        rhit_next    = rhit_reg;
        rval_next    = rval_reg;
        m_hit_next   = m_hit_reg;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = pidx_reg;
        ram_wdata    = {adj_age, e_freq, e_val, e_key};

        // output register drains independently
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    key_next   = s_tdata[31:0];
                    val_next   = s_tdata[63:32];
                    rhit_next  = 1'b0;
                    rval_next  = '0;
                    mode_next  = MODE_LOOKUP;
                    adj_next   = 1'b0;
                    touch_next = 1'b0;
                    iss_next   = '0;
                    found_next = 1'b0;
                    vic_next   = 1'b0;
                    free_next  = 1'b0;
                    state_next = ST_SWEEP;
                end
            end

            ST_SWEEP: begin
                // issue one read a cycle
                if (iss_reg < (AW+1)'(ENTRIES)) begin
                    pvld_next = 1'b1;
                    pidx_next = iss_reg[AW-1:0];
                    iss_next  = iss_reg + (AW+1)'(1);
                end
                // process the entry read last cycle
                if (pvld_reg) begin
                    if (is_touch) begin
                        ram_we    = 1'b1;
                        ram_wdata = {AW'(count_reg - CW'(1)),
                                     (e_freq != FREQ_MAX) ? (e_freq + FB'(1)) : e_freq,
                                     (op_reg == OP_PUT) ? val_reg : e_val,
                                     e_key};
                    end else if (do_adj) begin
                        ram_we = 1'b1;
                    end
                    if (cur_v && (e_key == key_reg) && !found_reg) begin
                        found_next = 1'b1;
                        fidx_next  = pidx_reg;
                        fage_next  = e_age;
                        fval_next  = e_val;
                    end
                    if (cur_v && (!vic_reg || (e_freq < vfreq_reg) ||
                                  ((e_freq == vfreq_reg) && (adj_age < vage_reg)))) begin
                        vic_next   = 1'b1;
                        vidx_next  = pidx_reg;
                        vfreq_next = e_freq;
                        vage_next  = adj_age;
                    end
                    if (!cur_v && !free_reg) begin
                        free_next = 1'b1;
                        frx_next  = pidx_reg;
                    end
                    if (pidx_reg == LAST_IDX) begin
                        state_next = ST_DECIDE;
                    end
                end
            end

            ST_DECIDE: begin
                // common sweep restart values
                iss_next   = '0;
                found_next = 1'b0;
                vic_next   = 1'b0;
                free_next  = 1'b0;
                if (mode_reg == MODE_TOUCH) begin
                    state_next = ST_DONE;
                end else if ((mode_reg == MODE_LOOKUP) && found_reg) begin
                    rhit_next  = 1'b1;
                    rval_next  = (op_reg == OP_GET) ? fval_reg : '0;
                    adj_next   = 1'b1;
                    touch_next = 1'b1;
                    skip_next  = fidx_reg;
                    thr_next   = fage_reg;
                    mode_next  = MODE_TOUCH;
                    state_next = ST_SWEEP;
                end else if ((mode_reg == MODE_LOOKUP) &&
                             ((op_reg == OP_GET) || (eff_cap == 32'd0))) begin
                    state_next = ST_DONE;
                end else if (need_evict) begin
                    // drop the victim, then sweep to close its rank
                    valid_next[vidx_reg] = 1'b0;
                    count_next = count_reg - CW'(1);
                    adj_next   = 1'b1;
                    touch_next = 1'b0;
                    skip_next  = vidx_reg;
                    thr_next   = vage_reg;
                    mode_next  = MODE_EVICT;
                    state_next = ST_SWEEP;
                end else begin
                    // insert into the first free slot as most recent
                    ram_we              = 1'b1;
                    ram_waddr           = frx_reg;
                    ram_wdata           = {AW'(count_reg), FB'(1), val_reg, key_reg};
                    valid_next[frx_reg] = 1'b1;
                    count_next          = count_reg + CW'(1);
                    state_next          = ST_DONE;
                end
            end

            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_hit_next   = rhit_reg;
                    m_data_next  = rval_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= MODE_LOOKUP;
            valid_reg   <= '0;
            count_reg   <= '0;
            iss_reg     <= '0;
            pvld_reg    <= 1'b0;
            adj_reg     <= 1'b0;
            touch_reg   <= 1'b0;
            found_reg   <= 1'b0;
            vic_reg     <= 1'b0;
            free_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            iss_reg     <= iss_next;
            pvld_reg    <= pvld_next;
            adj_reg     <= adj_next;
            touch_reg   <= touch_next;
            found_reg   <= found_next;
            vic_reg     <= vic_next;
            free_reg    <= free_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pidx_reg   <= pidx_next;
        skip_reg   <= skip_next;
        thr_reg    <= thr_next;
        op_reg     <= op_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        fidx_reg   <= fidx_next;
        fage_reg   <= fage_next;
        fval_reg   <= fval_next;
        vidx_reg   <= vidx_next;
        vfreq_reg  <= vfreq_next;
        vage_reg   <= vage_next;
        frx_reg    <= frx_next;
        rhit_reg   <= rhit_next;
        rval_reg   <= rval_next;
        m_hit_reg  <= m_hit_next;
        m_data_reg <= m_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_hit_reg;
    assign m_tdata  = m_data_reg;

    // fill count tracks the valid bits
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == 32'(count_reg))
        else $error("entry count out of step with valid bits");

    // fill never exceeds the table depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= 32'(ENTRIES))
        else $error("entry count above table depth");

    // an insert raises the fill by exactly one
    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE && ram_we) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not raise the entry count");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Testbench for lfu_cache_with_lru_tiebreak_unit: drives get/put beats with random
// gaps and stalls and checks each result against a behavioral LFU/LRU cache.
// Depends on lfucl_pkg and the RTL of the block.
module tb;
    import lfucl_pkg::*;

    localparam int NSLOT    = 16;
    localparam int FMAX     = 65535;
    localparam int WDOG_MAX = 5000;
    localparam int SETTLE   = 100;

    typedef struct packed {
        logic        op;
        logic [31:0] key;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] rdval;
    } rsp_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;    // [31:0] key, [63:32] value
    logic        s_tuser;    // [0] op
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [31:0] read_value
    logic        m_tuser;    // [0] hit
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lfu_cache_with_lru_tiebreak_unit uut (.*);

    // cache mirror
    bit          c_valid [NSLOT];
    logic [31:0] c_key   [NSLOT];
    logic [31:0] c_val   [NSLOT];
    int          c_freq  [NSLOT];
    int          c_age   [NSLOT];
    int          c_count;
    int          c_cap;

    req_t        req_q [$];
    rsp_t        rsp_q [$];
    int          errors;
    int          gap_left;
    bit          no_idle;
    bit          rx_hold_req;
    int          rx_hold_left;
    int          idle_cycles;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Drop slot s from the recency order
    function automatic void close_rank(int s);
        for (int j = 0; j < NSLOT; j++)
            if (c_valid[j] && j != s && c_age[j] > c_age[s]) c_age[j]--;
    endfunction

    // Evict lowest count, oldest among ties
    function automatic void evict_victim();
        int v;
        v = -1;
        for (int j = 0; j < NSLOT; j++) begin
            if (!c_valid[j]) continue;
            if (v < 0 || c_freq[j] < c_freq[v] ||
                (c_freq[j] == c_freq[v] && c_age[j] < c_age[v])) v = j;
        end
        if (v < 0) return;
        close_rank(v);
        c_valid[v] = 0;
        c_count--;
    endfunction

    function automatic rsp_t cache_access(req_t r);
        rsp_t res;
        int   f, slot, cap;
        res = '0;
        f = -1;
        slot = -1;
        cap = (c_cap > NSLOT) ? NSLOT : c_cap;
        for (int j = 0; j < NSLOT; j++)
            if (f < 0 && c_valid[j] && c_key[j] == r.key) f = j;
        if (f >= 0) begin
            if (c_freq[f] < FMAX) c_freq[f]++;
            close_rank(f);
            c_age[f] = c_count - 1;
            res.hit = 1'b1;
            if (r.op == OP_GET) res.rdval = c_val[f];
            else c_val[f] = r.value;
            return res;
        end
        if (r.op == OP_PUT && cap > 0) begin
            while (c_count >= cap && c_count > 0) evict_victim();
            for (int j = 0; j < NSLOT; j++)
                if (slot < 0 && !c_valid[j]) slot = j;
            if (slot >= 0) begin
                c_valid[slot] = 1;
                c_key[slot] = r.key;
                c_val[slot] = r.value;
                c_freq[slot] = 1;
                c_age[slot] = c_count;
                c_count++;
            end
        end
        return res;
    endfunction

    // Gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_idle || r < 50) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // Request driver
    always @(posedge aclk) begin
        req_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready)
                rsp_q.push_back(cache_access({s_tuser, s_tdata[31:0], s_tdata[63:32]}));
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (req_q.size() > 0) begin
                    r = req_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= r.op;
                    s_tdata  <= {r.value, r.key};
                    gap_left = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stalls
    always @(posedge aclk) begin
        rsp_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (rsp_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result beat: hit=%0b value=%h", m_tuser, m_tdata);
                end else begin
                    e = rsp_q.pop_front();
                    if (e.hit !== m_tuser || e.rdval !== m_tdata) begin
                        errors++;
                        if (errors <= 10)
                            $display({"result mismatch: expected hit=%0b value=%h, ",
                                      "got hit=%0b value=%h"},
                                     e.hit, e.rdval, m_tuser, m_tdata);
                    end
                end
            end
            if (rx_hold_req) begin
                rx_hold_req = 0;
                rx_hold_left = 400;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (pick_gap() == 0);
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WDOG_MAX) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic send(logic op, logic [31:0] key, logic [31:0] value);
        req_q.push_back('{op, key, value});
    endtask

    // Wait until every queued beat has been sent and answered; checked at the
    // falling edge so the driver's updates of the same rising edge are visible
    task automatic drain();
        do @(negedge aclk);
        while (req_q.size() > 0 || s_tvalid || rsp_q.size() > 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Capacity write while the block is idle
    task automatic set_capacity(logic [31:0] v);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(REG_CAPACITY) * 3'd4;
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        c_cap = v & 32'h1f;
    endtask

    // Random phase over a key pool sized around the capacity
    task automatic random_phase(int n, int pool_n);
        logic [31:0] pool [$];
        for (int i = 0; i < pool_n; i++) pool.push_back($urandom);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 85)
                send(1'($urandom_range(1)), pool[$urandom_range(pool_n - 1)], $urandom);
            else
                send(1'($urandom_range(1)), $urandom, $urandom);
        end
    endtask

    initial begin
        int caps [7] = '{16, 1, 4, 31, 0, 8, 2};
        errors = 0;
        idle_cycles = 0;
        no_idle = 0;
        rx_hold_req = 0;
        c_cap = CAP_RESET;
        c_count = 0;
        for (int j = 0; j < NSLOT; j++) c_valid[j] = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: key/value extremes, hits, misses, overwrite
        send(OP_GET, 32'h0, 32'h0);
        send(OP_PUT, 32'h0, 32'h8000_0000);
        send(OP_PUT, 32'hffff_ffff, 32'h7fff_ffff);
        send(OP_GET, 32'h0, 32'hffff_ffff);
        send(OP_GET, 32'hffff_ffff, 32'h0);
        send(OP_PUT, 32'h0, 32'hffff_ffff);
        send(OP_GET, 32'h0, 32'h0);
        send(OP_GET, 32'h1234_5678, 32'h0);
        // Fill the table, then a put miss evicts lowest count / oldest
        for (int i = 1; i <= 14; i++) send(OP_PUT, 32'h100 + i, i);
        send(OP_PUT, 32'hdead_beef, 32'h1);
        send(OP_GET, 32'h101, 32'h0);
        drain();

        // Capacity lowered below the fill: one put evicts several
        set_capacity(3);
        send(OP_PUT, 32'h55, 32'h55);
        send(OP_GET, 32'h0, 32'h0);
        // Capacity zero: nothing stored, held entries still hit
        set_capacity(0);
        send(OP_PUT, 32'h77, 32'h77);
        send(OP_GET, 32'h77, 32'h0);
        send(OP_PUT, 32'h55, 32'h66);
        send(OP_GET, 32'h55, 32'h0);
        set_capacity(31);
        send(OP_PUT, 32'h77, 32'h77);
        send(OP_GET, 32'h77, 32'h0);

        // Random phases across capacities, with sender pauses and one long receiver stall
        for (int p = 0; p < 7; p++) begin
            set_capacity(caps[p]);
            no_idle = (p == 2);
            random_phase(110, (caps[p] > 16 ? 16 : caps[p]) + 4);
            if (p == 1) begin
                rx_hold_req = 1;
                drain();
            end
            random_phase(110, (caps[p] > 16 ? 16 : caps[p]) + 4);
        end
        set_capacity(16);
        drain();

        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// File: files.f
src/lfucl_pkg.sv
src/lfucl_ram.sv
src/lfucl_apb.sv
src/lfu_cache_with_lru_tiebreak_unit.sv
sim/tb.sv
